### rtl/nsu_pkg.sv
// ----------------------------------------------------------------------------
// nsu_pkg: shared constants and types for the normalized sinc unit
// Fixed-point constants, series divisors and their reciprocals, pipeline depths.
// ----------------------------------------------------------------------------
package nsu_pkg;

	localparam int unsigned SERIES_TERMS = 10;
	localparam int unsigned TERM_LAT     = 3;
	localparam int unsigned DIV_STAGES   = 4;
	localparam int unsigned RECIP_SHIFT  = 32;

	localparam logic [31:0] PI_Q30 = 32'd3373259426;

	// t^2 in Q30, below 2.47 * 2^30
	typedef logic [31:0] usq_t;
	// sin(t)/t in Q30, up to 2^30 inclusive
	typedef logic [30:0] acc_t;

	localparam acc_t Q30_ONE = acc_t'(1) << 30;

	// divisor (2k)(2k+1) of term i, innermost term first (k = 10 down to 1)
	function automatic logic [8:0] term_div(input int unsigned i);
		logic [8:0] d;
		case (i)
			0: d = 9'd420;
			1: d = 9'd342;
			2: d = 9'd272;
			3: d = 9'd210;
			4: d = 9'd156;
			5: d = 9'd110;
			6: d = 9'd72;
			7: d = 9'd42;
			8: d = 9'd20;
			9: d = 9'd6;
			default: d = 9'd6;
		endcase
		return d;
	endfunction

	// floor(2^32 / divisor); quotient estimate is then low by at most one
	function automatic logic [29:0] term_recip(input int unsigned i);
		logic [29:0] r;
		case (i)
			0: r = 30'd10226112;
			1: r = 30'd12558383;
			2: r = 30'd15790320;
			3: r = 30'd20452225;
			4: r = 30'd27531841;
			5: r = 30'd39045157;
			6: r = 30'd59652323;
			7: r = 30'd102261126;
			8: r = 30'd214748364;
			9: r = 30'd715827882;
			default: r = 30'd715827882;
		endcase
		return r;
	endfunction

endpackage

### rtl/nsu_if.sv
// ----------------------------------------------------------------------------
// nsu_if: request channels of the normalized sinc unit
// Valid/ready channels for the input element and the result.
// ----------------------------------------------------------------------------
interface nsu_in_if #(parameter int XW = 24);
	logic          valid;
	logic          ready;
	logic [XW-1:0] x_value;

	modport source(output valid, output x_value, input ready);
	modport sink(input valid, input x_value, output ready);
endinterface

interface nsu_out_if #(parameter int SW = 16);
	logic                 valid;
	logic                 ready;
	logic signed [SW-1:0] sinc_value;
	logic                 was_zero;

	modport source(output valid, output sinc_value, output was_zero, input ready);
	modport sink(input valid, input sinc_value, input was_zero, output ready);
endinterface

### rtl/nsu_term.sv
// ----------------------------------------------------------------------------
// nsu_term: one step of the nested sin(t)/t series
// acc' = 1 - round(u * acc / d) in Q30, three register stages.
// ----------------------------------------------------------------------------
module nsu_term #(
	parameter int unsigned TERM = 0
) (
	input  logic           clk,
	input  logic           en,
	input  nsu_pkg::usq_t  u_in,
	input  nsu_pkg::acc_t  acc_in,
	output nsu_pkg::usq_t  u_out,
	output nsu_pkg::acc_t  acc_out
);
	import nsu_pkg::*;

	localparam logic [8:0]  DIV   = term_div(TERM);
	localparam logic [29:0] RECIP = term_recip(TERM);

	logic [63:0] prod1;
	logic [63:0] sum1;
	logic [63:0] prod2;
	logic [41:0] qd;
	logic [41:0] rem;
	logic [32:0] q;
	acc_t        acc_nx;

	logic [31:0] m_s1, m_s2;
	logic [31:0] q0_s2;
	usq_t        u_s1, u_s2, u_s3;
	acc_t        acc_s3;

	// floor((u*acc + d*2^29) / 2^30), then divide that by d
	assign prod1 = 64'(u_in) * 64'(acc_in);
	assign sum1  = prod1 + (64'(DIV) << 29);
	assign prod2 = 64'(m_s1) * 64'(RECIP);

	always_comb begin
		qd  = 42'(q0_s2) * 42'(DIV);
		rem = 42'(m_s2) - qd;
		q   = (rem >= 42'(DIV)) ? (33'(q0_s2) + 33'd1) : 33'(q0_s2);
		acc_nx = (q >= 33'(Q30_ONE)) ? '0 : acc_t'(33'(Q30_ONE) - q);
	end

	always_ff @(posedge clk) begin
		if (en) begin
			m_s1   <= sum1[61:30];
			u_s1   <= u_in;
			q0_s2  <= prod2[RECIP_SHIFT +: 32];
			m_s2   <= m_s1;
			u_s2   <= u_s1;
			acc_s3 <= acc_nx;
			u_s3   <= u_s2;
		end
	end

	assign u_out   = u_s3;
	assign acc_out = acc_s3;

endmodule

### rtl/nsu_div.sv
// ----------------------------------------------------------------------------
// nsu_div: pipelined restoring divider
// Unsigned quotient of num / den, known to fit QS bits; QS / DIV_STAGES bits
// are resolved per stage.
// ----------------------------------------------------------------------------
module nsu_div #(
	parameter int DW = 48,
	parameter int XW = 24,
	parameter int QS = 16
) (
	input  logic          clk,
	input  logic          en,
	input  logic [DW-1:0] num,
	input  logic [XW-1:0] den,
	output logic [QS-1:0] quo
);
	import nsu_pkg::*;

	localparam int SPS = QS / DIV_STAGES;

	logic [DW-1:0] num_s [DIV_STAGES];
	logic [XW-1:0] den_s [DIV_STAGES];
	logic [XW-1:0] rem_s [DIV_STAGES];
	logic [QS-1:0] quo_s [DIV_STAGES];

	for (genvar g = 0; g < DIV_STAGES; g++) begin : g_stage
		logic [DW-1:0] num_i;
		logic [XW-1:0] den_i;
		logic [XW-1:0] rem_i;
		logic [QS-1:0] quo_i;
		logic [XW-1:0] rem_o;
		logic [QS-1:0] quo_o;

		if (g == 0) begin : g_first
			// top bits already below den since the quotient fits QS bits
			assign num_i = num;
			assign den_i = den;
			assign rem_i = XW'(num >> QS);
			assign quo_i = '0;
		end else begin : g_next
			assign num_i = num_s[g-1];
			assign den_i = den_s[g-1];
			assign rem_i = rem_s[g-1];
			assign quo_i = quo_s[g-1];
		end

		always_comb begin
			logic [XW:0] r;
			rem_o = rem_i;
			quo_o = quo_i;
			for (int j = 0; j < SPS; j++) begin
				r = {rem_o, num_i[QS-1-(g*SPS+j)]};
				if (r >= {1'b0, den_i}) begin
					r = r - {1'b0, den_i};
					quo_o = {quo_o[QS-2:0], 1'b1};
				end else begin
					quo_o = {quo_o[QS-2:0], 1'b0};
				end
				rem_o = r[XW-1:0];
			end
		end

		always_ff @(posedge clk) begin
			if (en) begin
				num_s[g] <= num_i;
				den_s[g] <= den_i;
				rem_s[g] <= rem_o;
				quo_s[g] <= quo_o;
			end
		end
	end

	assign quo = quo_s[DIV_STAGES-1];

endmodule

### rtl/normalized_sinc_unit_top.sv
// ----------------------------------------------------------------------------
// normalized_sinc_unit_top: normalized sinc, sin(pi*x)/(pi*x), per element
// Fixed-point elementwise kernel: Q8.16 in, Q2.14 out, exact 1.0 for zero.
// ----------------------------------------------------------------------------
// One request enters per clock while the pipe is not held; the sustained
// rate is one element per cycle while results are taken. The pipe is a chain of
// stages: input decode (1), t = pi*|f| (1), t^2 (1), ten series steps of three
// stages each (30), the f*S numerator (1), a four-stage restoring divider (4)
// and the output register (1). The whole pipe advances together and holds
// when the output register is full and not taken; in that case ready drops.
// x is split as n + f with n the nearest integer (halves round up) and
// f in [-1/2, 1/2); result = (-1)^n * |f| * sin(t)/t / |x| with t = pi*f,
// rounded to nearest and limited to 1.0. Zero gives 1.0 with was_zero set.
// ----------------------------------------------------------------------------
module normalized_sinc_unit_top #(
	parameter int IN_FRAC_BITS  = 16,
	parameter int IN_INT_BITS   = 8,
	parameter int OUT_FRAC_BITS = 14
) (
	input  logic      clk,
	input  logic      arst_n,
	nsu_in_if.sink    in_ch,
	nsu_out_if.source out_ch
);
	import nsu_pkg::*;

	localparam int IW  = IN_INT_BITS + IN_FRAC_BITS;
	localparam int FW  = IN_FRAC_BITS;
	localparam int OW  = OUT_FRAC_BITS + 2;
	localparam int DSH = 30 - OUT_FRAC_BITS;           // |x| to divisor scale
	localparam int PW  = FW + 31;                      // |f| * S
	localparam int HW  = IW + DSH;                     // divisor
	localparam int NW  = ((PW > HW) ? PW : HW) + 1;    // numerator with round
	localparam int DW  = NW - DSH;
	localparam int QS  = DIV_STAGES * ((OW + DIV_STAGES - 1) / DIV_STAGES);
	localparam int SERIES_END = 3 + SERIES_TERMS * TERM_LAT;   // stage number
	localparam int DEPTH      = SERIES_END + 1 + DIV_STAGES;   // before output reg

	typedef struct packed {
		logic          zero;
		logic          neg;
		logic [FW-1:0] fm;
		logic [IW-1:0] xm;
	} side_t;

	localparam logic [IW-1:0] HALF_X = IW'(1) << (FW - 1);
	localparam logic [FW-1:0] HALF_F = FW'(1) << (FW - 1);
	localparam logic [QS-1:0] ONE_Q  = QS'(1) << OUT_FRAC_BITS;

	logic en;

	// ---------------- decode of the incoming element ----------------
	logic [IW-1:0] v;
	logic [IW-1:0] shifted;
	logic [FW-1:0] frac;
	logic          odd, fneg, xneg;
	side_t         side_in;

	always_comb begin
		v       = in_ch.x_value;
		shifted = v + HALF_X;
		odd     = shifted[FW];
		frac    = shifted[FW-1:0];
		fneg    = frac < HALF_F;
		xneg    = v[IW-1];
		side_in.zero = (v == '0);
		side_in.fm   = fneg ? (HALF_F - frac) : (frac - HALF_F);
		side_in.xm   = xneg ? (~v + IW'(1)) : v;
		side_in.neg  = odd ^ fneg ^ xneg;
	end

	// ---------------- sideband and valid line ----------------
	// side_s[k-1] belongs to stage k
	side_t            side_s [DEPTH];
	logic [DEPTH-1:0] vld_s;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s <= '0;
		end else if (en) begin
			vld_s <= {vld_s[DEPTH-2:0], in_ch.valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			side_s[0] <= side_in;
			for (int i = 1; i < DEPTH; i++) begin
				side_s[i] <= side_s[i-1];
			end
		end
	end

	// ---------------- t = pi*|f| and u = t^2, Q30 ----------------
	logic [61:0] t_prod;
	logic [61:0] u_prod;
	logic [30:0] t_s2;
	usq_t        u_s3;

	assign t_prod = (62'(30'(side_s[0].fm) << (30 - FW)) * 62'(PI_Q30)) + (62'(1) << 29);
	assign u_prod = (62'(t_s2) * 62'(t_s2)) + (62'(1) << 29);

	always_ff @(posedge clk) begin
		if (en) begin
			t_s2 <= t_prod[60:30];
			u_s3 <= u_prod[61:30];
		end
	end

	// ---------------- nested series for sin(t)/t ----------------
	usq_t u_ch   [SERIES_TERMS+1];
	acc_t acc_ch [SERIES_TERMS+1];

	assign u_ch[0]   = u_s3;
	assign acc_ch[0] = Q30_ONE;

	for (genvar k = 0; k < SERIES_TERMS; k++) begin : g_term
		nsu_term #(.TERM(k)) u_term (
			.clk    (clk),
			.en     (en),
			.u_in   (u_ch[k]),
			.acc_in (acc_ch[k]),
			.u_out  (u_ch[k+1]),
			.acc_out(acc_ch[k+1])
		);
	end

	// ---------------- numerator |f|*S + divisor/2 ----------------
	logic [NW-1:0] num_nx;
	logic [NW-1:0] num_s34;

	assign num_nx = (NW'(side_s[SERIES_END-1].fm) * NW'(acc_ch[SERIES_TERMS]))
	              + ((NW'(side_s[SERIES_END-1].xm) << DSH) >> 1);

	always_ff @(posedge clk) begin
		if (en) begin
			num_s34 <= num_nx;
		end
	end

	// ---------------- divide by |x| ----------------
	logic [QS-1:0] quo;

	nsu_div #(.DW(DW), .XW(IW), .QS(QS)) u_div (
		.clk (clk),
		.en  (en),
		.num (DW'(num_s34 >> DSH)),
		.den (side_s[SERIES_END].xm),
		.quo (quo)
	);

	// ---------------- output register ----------------
	logic [QS-1:0]        mag;
	logic signed [OW-1:0] res;
	logic                 out_valid_q;
	logic signed [OW-1:0] sinc_q;
	logic                 was_zero_q;

	always_comb begin
		mag = (quo > ONE_Q) ? ONE_Q : quo;
		if (side_s[DEPTH-1].zero) begin
			res = OW'(ONE_Q);
		end else if (side_s[DEPTH-1].neg) begin
			res = -OW'(mag);
		end else begin
			res = OW'(mag);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (en) begin
			out_valid_q <= vld_s[DEPTH-1];
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			sinc_q     <= res;
			was_zero_q <= side_s[DEPTH-1].zero;
		end
	end

	// pipe moves whenever the output slot is free or being drained
	assign en = !out_valid_q || out_ch.ready;

	assign in_ch.ready       = en;
	assign out_ch.valid      = out_valid_q;
	assign out_ch.sinc_value = sinc_q;
	assign out_ch.was_zero   = was_zero_q;

endmodule

### rtl/nsu_checker.sv
// ----------------------------------------------------------------------------
// nsu_checker: port-level checks for the normalized sinc unit
// Handshake holding, zero rule, result range and flow control.
// ----------------------------------------------------------------------------
module nsu_checker #(
	parameter int OUT_FRAC_BITS = 14
) (
	input logic                         clk,
	input logic                         arst_n,
	input logic                         in_ready,
	input logic                         out_valid,
	input logic                         out_ready,
	input logic signed [OUT_FRAC_BITS+1:0] sinc_value,
	input logic                         was_zero
);
	localparam int OW = OUT_FRAC_BITS + 2;
	localparam logic signed [OW-1:0] ONE  = OW'(1) << OUT_FRAC_BITS;
	localparam logic signed [OW-1:0] MONE = -(OW'(1) << OUT_FRAC_BITS);

	a_hold_valid: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid)
		else $error("result dropped while stalled");

	a_hold_data: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> $stable(sinc_value) && $stable(was_zero))
		else $error("result changed while stalled");

	a_zero_one: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && was_zero |-> sinc_value == ONE)
		else $error("zero input did not give 1.0");

	a_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (sinc_value <= ONE) && (sinc_value >= MONE))
		else $error("result beyond +-1.0");

	a_flow: assert property (@(posedge clk) disable iff (!arst_n)
		in_ready == (!out_valid || out_ready))
		else $error("input ready does not follow output slot");

endmodule

bind normalized_sinc_unit_top nsu_checker #(.OUT_FRAC_BITS(OUT_FRAC_BITS)) u_nsu_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_ready  (in_ch.ready),
	.out_valid (out_ch.valid),
	.out_ready (out_ch.ready),
	.sinc_value(out_ch.sinc_value),
	.was_zero  (out_ch.was_zero)
);

### bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top: testbench of the normalized sinc unit
// Drives Q8.16 elements through the valid/ready input channel, predicts each
// Q2.14 sinc result in fixed point and compares it with the output channel.
// ----------------------------------------------------------------------------
module tb_top;

	localparam int XW = 24;
	localparam int SW = 16;
	localparam int FRAC_IN = 16;
	localparam int FRAC_OUT = 14;
	localparam logic [63:0] ONE_Q30 = 64'd1 << 30;
	localparam logic [63:0] PI_FIX = 64'd3373259426;
	localparam int PIPE_DEPTH = 39;

	typedef struct packed {
		logic signed [SW-1:0] sinc_value;
		logic                 was_zero;
	} sinc_res_t;

	logic clk;
	logic arst_n;

	nsu_in_if  #(.XW(XW)) in_ch();
	nsu_out_if #(.SW(SW)) out_ch();

	normalized_sinc_unit_top u_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (in_ch),
		.out_ch (out_ch)
	);

	sinc_res_t expected_sincs[$];
	int        fail_count;
	// idle rates in percent for each side
	int        send_gap_pct;
	int        recv_stall_pct;

	initial begin
		clk = 1'b0;
		forever #5 clk = ~clk;
	end

	// Fixed-length series for sin(t)/t in Q30; t = pi*|f|, |f| in Q30.
	function automatic logic [63:0] sin_ratio_q30(input logic [63:0] f30);
		logic [63:0] t;
		logic [63:0] u;
		logic [63:0] acc;
		logic [63:0] d;
		logic [63:0] term;
		t = (f30 * PI_FIX + (ONE_Q30 >> 1)) >> 30;
		u = (t * t + (ONE_Q30 >> 1)) >> 30;
		acc = ONE_Q30;
		for (int k = 10; k >= 1; k--) begin
			d = 64'(2 * k) * 64'(2 * k + 1);
			d = d << 30;
			term = (u * acc + d / 2) / d;
			acc = (term >= ONE_Q30) ? 64'd0 : ONE_Q30 - term;
		end
		return acc;
	endfunction

	// Expected sinc of one Q8.16 element.
	function automatic sinc_res_t predict_sinc(input logic [XW-1:0] x);
		sinc_res_t   r;
		logic [63:0] v;
		logic [63:0] xm;
		logic [63:0] sh;
		logic [63:0] frac;
		logic [63:0] fm;
		logic [63:0] s;
		logic [63:0] den;
		logic [63:0] mag;
		logic        xneg;
		logic        fneg;
		logic        odd;
		logic [63:0] half;
		half = 64'd1 << (FRAC_IN - 1);
		v = 64'(x);
		if (v == 0) begin
			r.sinc_value = SW'(1 << FRAC_OUT);
			r.was_zero = 1'b1;
			return r;
		end
		xneg = x[XW-1];
		xm = xneg ? 64'(XW'(-x)) : v;
		sh = v + half;
		odd = sh[FRAC_IN];
		frac = sh & ((64'd1 << FRAC_IN) - 1);
		fneg = frac < half;
		fm = fneg ? half - frac : frac - half;
		s = sin_ratio_q30(fm << (30 - FRAC_IN));
		den = xm << (30 - FRAC_OUT);
		mag = (fm * s + den / 2) / den;
		if (mag > (64'd1 << FRAC_OUT))
			mag = 64'd1 << FRAC_OUT;
		r.sinc_value = ((odd ^ fneg ^ xneg) && mag != 0) ? -SW'(mag) : SW'(mag);
		r.was_zero = 1'b0;
		return r;
	endfunction

	// Send one request; valid stays up across back-to-back requests.
	task automatic send_element(input logic [XW-1:0] x);
		while (($urandom % 100) < send_gap_pct) begin
			in_ch.valid <= 1'b0;
			in_ch.x_value <= XW'($urandom);
			@(negedge clk);
		end
		in_ch.valid <= 1'b1;
		in_ch.x_value <= x;
		expected_sincs.push_back(predict_sinc(x));
		@(posedge clk);
		while (!in_ch.ready)
			@(posedge clk);
		@(negedge clk);
	endtask

	// Receiver stalls at random by the current rate.
	always @(negedge clk)
		out_ch.ready <= arst_n && (($urandom % 100) >= recv_stall_pct);

	// Compare each accepted result with the oldest expectation.
	always @(posedge clk) begin
		sinc_res_t want;
		if (arst_n && out_ch.valid && out_ch.ready) begin
			if (expected_sincs.size() == 0) begin
				$display("%0t: unexpected result sinc=%0d zero=%0b", $realtime,
					out_ch.sinc_value, out_ch.was_zero);
				fail_count++;
			end else begin
				want = expected_sincs.pop_front();
				if (out_ch.sinc_value !== want.sinc_value) begin
					$display("%0t: sinc_value expected %0d actual %0d", $realtime,
						want.sinc_value, out_ch.sinc_value);
					fail_count++;
				end
				if (out_ch.was_zero !== want.was_zero) begin
					$display("%0t: was_zero expected %0b actual %0b", $realtime,
						want.was_zero, out_ch.was_zero);
					fail_count++;
				end
			end
		end
	end

	// Zero, the field extremes, integers, exact halves and near-zero values.
	task automatic test_directed();
		logic [XW-1:0] pts[$];
		pts = '{24'h000000, 24'h7fffff, 24'h800000, 24'h800001, 24'h000001,
			24'hffffff, 24'h010000, 24'hff0000, 24'h008000, 24'hff8000,
			24'h018000, 24'hfe8000, 24'h7f8000, 24'h004000, 24'hffc000,
			24'h00ffff, 24'h000100, 24'h7f0000, 24'h555555, 24'haaaaaa,
			24'h00c000, 24'h028000};
		foreach (pts[i])
			send_element(pts[i]);
	endtask

	// Mostly small magnitudes where sinc is large, plus full-range values,
	// integers and halves.
	task automatic test_random(input int count);
		logic [XW-1:0] x;
		for (int i = 0; i < count; i++) begin
			case ($urandom_range(0, 4))
				0: x = XW'($urandom);
				1: x = XW'($signed($urandom_range(0, 8 << 16)) - (4 << 16));
				2: x = {8'($urandom_range(0, 255)), 16'h0};
				3: x = XW'($signed($urandom_range(0, 40)) - 20) << 15;
				default: x = XW'($signed($urandom_range(0, 512)) - 256);
			endcase
			if ($urandom_range(0, 2) == 0 && i % 3 == 2)
				x = {x[7:0], 16'h0};
			send_element(x);
		end
	endtask

	task automatic wait_drain();
		in_ch.valid <= 1'b0;
		while (expected_sincs.size() != 0)
			@(posedge clk);
		repeat (PIPE_DEPTH + 10) @(posedge clk);
	endtask

	initial begin
		fail_count = 0;
		send_gap_pct = 9;
		recv_stall_pct = 67;
		arst_n = 1'b0;
		in_ch.valid = 1'b0;
		in_ch.x_value = '0;
		out_ch.ready = 1'b0;
		repeat (8) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_random(480);
		send_gap_pct = 67;
		recv_stall_pct = 9;
		test_random(480);
		send_gap_pct = 0;
		recv_stall_pct = 0;
		test_random(490);
		wait_drain();
		if (fail_count == 0)
			$display("PASS");
		else
			$display("FAIL");
		$finish;
	end

	// Run limit far above the slowest correct run.
	initial begin
		#2000000;
		$display("FAIL");
		$finish;
	end

endmodule
